// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lts_pkg.sv =====
`default_nettype none

package lts_pkg;

    // field widths
    localparam int TICKET_W    = 7;
    localparam int POOL_W      = 13;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 16;
    localparam int RANDOM_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // defaults
    localparam int DEF_SLOT_COUNT = 64;

    localparam logic [TICKET_W-1:0] SYSTEM_GRANT_RST    = 7'd40;
    localparam logic [TICKET_W-1:0] USER_GRANT_RST      = 7'd20;
    localparam logic [TICKET_W-1:0] TICKET_LIMIT_RST    = 7'd100;
    localparam logic [COUNT_W-1:0]  BLOCK_THRESHOLD_RST = 16'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYSTEM_GRANT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_GRANT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKET_LIMIT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_THRESHOLD = 2'd3;

    typedef enum logic [1:0] {
        OP_START_SYS = 2'd0,
        OP_START_USR = 2'd1,
        OP_STOP      = 2'd2,
        OP_QUANTUM   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  block_count;
        logic [RANDOM_W-1:0] random_value;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic                winner_valid;
        logic [SLOT_W-1:0]   winner_slot;
        logic [POOL_W-1:0]   pool_total;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/lts_stream_if.sv =====
`default_nettype none

// valid/ready channel carrying one payload per transaction
interface lts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/lts_ticket_mem.sv =====
`default_nettype none

module lts_ticket_mem
    import lts_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
    input  wire logic [TICKET_W-1:0]           wr_data,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
    output logic      [TICKET_W-1:0]           rd_data
);

    logic [TICKET_W-1:0]   mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic                  rd_vld_reg;
    logic [TICKET_W-1:0]   rd_data_reg;

    // storage array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // written marks, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/lts_mod_unit.sv =====
`default_nettype none

`include "assert_macros.svh"

module lts_mod_unit
    import lts_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [RANDOM_W-1:0] dividend,
    input  wire logic [POOL_W-1:0]   divisor,
    output logic                     done,
    output logic      [POOL_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(RANDOM_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RANDOM_W-1:0] quo_reg;
    logic [POOL_W-1:0]   rem_reg;
    logic [POOL_W-1:0]   div_reg;
    logic [POOL_W:0]     trial;
    logic [POOL_W-1:0]   rem_next;

    // one restoring step per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[RANDOM_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = POOL_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[POOL_W-1:0];
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RANDOM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifter and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[RANDOM_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    `ASSERT_CLK(a_rem_below_divisor, clk, rst_n, done |-> (rem_reg < div_reg),
                "remainder not below divisor")
    `ASSERT_CLK(a_start_sets_busy, clk, rst_n, start |=> busy_reg,
                "unit not busy after start")

endmodule

`default_nettype wire

// ===== rtl/lottery_ticket_scheduler_top.sv =====
`default_nettype none

// Lottery ticket scheduler. Slot ticket counts live in a one-port-read,
// one-port-write memory with registered read data; the pool total is a
// register. Each request transaction on req gives exactly one response
// transaction on rsp. A start or stop request passes through a memory
// read, an update and write back, and a response before the next request
// can be accepted. An out-of-quantum request that draws a lottery runs a
// bit-serial modulo of the draw by the pool, then a walk over the ticket
// memory at one entry per cycle until the running sum passes the draw.
// Only one request is in flight at a time; a new request is accepted while
// the previous response still waits in the output register. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module lottery_ticket_scheduler_top
    import lts_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    lts_stream_if.sink                  req,
    lts_stream_if.source                rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W    = $clog2(SLOT_COUNT);
    localparam int RUN_BITS = $clog2(SLOT_COUNT * (2 ** TICKET_W - 1) + 1);
    localparam int RUN_W    = (RUN_BITS > POOL_W) ? RUN_BITS : POOL_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // configuration registers
    logic [TICKET_W-1:0] sys_grant_reg;
    logic [TICKET_W-1:0] usr_grant_reg;
    logic [TICKET_W-1:0] limit_reg;
    logic [COUNT_W-1:0]  thresh_reg;

    // control state
    state_t            st_reg, st_next;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic              out_valid_reg, out_valid_next;

    // request payload and working registers
    op_t                 op_reg, op_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [COUNT_W-1:0]  blocks_reg, blocks_next;
    logic [RANDOM_W-1:0] rnd_reg, rnd_next;
    status_t             status_reg, status_next;
    logic                wvalid_reg, wvalid_next;
    logic [SLOT_W-1:0]   winner_reg, winner_next;
    logic [POOL_W-1:0]   winning_reg, winning_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    rsp_t                out_reg, out_next;

    // memory and divider hookup
    logic                mem_we;
    logic [TICKET_W-1:0] mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [TICKET_W-1:0] mem_rdata;
    logic                div_start;
    logic                div_done;
    logic [POOL_W-1:0]   div_rem;

    // update datapath
    logic [TICKET_W-1:0] grant_amt;
    logic [TICKET_W:0]   grant_sum;
    logic                grant_over;
    logic                upd_refused;
    logic                upd_we;
    logic [TICKET_W-1:0] upd_wdata;
    logic [POOL_W-1:0]   upd_pool;
    logic [RUN_W-1:0]    run_sum;
    logic                accept;
    logic                in_range;

    assign accept   = req.valid && req.ready;
    assign in_range = 32'(req.payload.slot) < SLOT_COUNT;

    lts_ticket_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (slot_reg),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    lts_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (upd_pool),
        .done      (div_done),
        .remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_grant_reg <= SYSTEM_GRANT_RST;
            usr_grant_reg <= USER_GRANT_RST;
            limit_reg     <= TICKET_LIMIT_RST;
            thresh_reg    <= BLOCK_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYSTEM_GRANT:    sys_grant_reg <= TICKET_W'(cfg_data);
                CFG_USER_GRANT:      usr_grant_reg <= TICKET_W'(cfg_data);
                CFG_TICKET_LIMIT:    limit_reg     <= TICKET_W'(cfg_data);
                CFG_BLOCK_THRESHOLD: thresh_reg    <= cfg_data;
            endcase
        end
    end

    // slot update from the read-back ticket count
    always_comb
    begin
        unique case (op_reg)
            OP_START_SYS: grant_amt = sys_grant_reg;
            OP_START_USR: grant_amt = usr_grant_reg;
            default:      grant_amt = TICKET_W'(1);
        endcase
        grant_sum   = {1'b0, mem_rdata} + {1'b0, grant_amt};
        grant_over  = grant_sum > {1'b0, limit_reg};
        upd_refused = 1'b0;
        upd_we      = 1'b0;
        upd_wdata   = '0;
        upd_pool    = pool_reg;
        unique case (op_reg)
            OP_STOP:
            begin
                upd_we   = 1'b1;
                upd_pool = pool_reg - POOL_W'(mem_rdata);
            end
            OP_QUANTUM:
            begin
                if (blocks_reg < thresh_reg)
                begin
                    // take one ticket, never below one
                    if (mem_rdata < TICKET_W'(2))
                    begin
                        upd_refused = 1'b1;
                    end
                    else
                    begin
                        upd_we    = 1'b1;
                        upd_wdata = mem_rdata - 1'b1;
                        upd_pool  = pool_reg - 1'b1;
                    end
                end
                else if (grant_over)
                begin
                    upd_refused = 1'b1;
                end
                else
                begin
                    upd_we    = 1'b1;
                    upd_wdata = grant_sum[TICKET_W-1:0];
                    upd_pool  = pool_reg + 1'b1;
                end
            end
            default:
            begin
                // both start requests
                if (grant_over)
                begin
                    upd_refused = 1'b1;
                end
                else
                begin
                    upd_we    = 1'b1;
                    upd_wdata = grant_sum[TICKET_W-1:0];
                    upd_pool  = pool_reg + POOL_W'(grant_amt);
                end
            end
        endcase
    end

    assign mem_we    = (st_reg == ST_UPD) && upd_we;
    assign mem_wdata = upd_wdata;
    assign div_start = (st_reg == ST_UPD) && (op_reg == OP_QUANTUM) && (upd_pool != '0);
    assign run_sum   = run_reg + RUN_W'(mem_rdata);

    // sequencer
    always_comb
    begin
        st_next        = st_reg;
        pool_next      = pool_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        blocks_next    = blocks_reg;
        rnd_next       = rnd_reg;
        status_next    = status_reg;
        wvalid_next    = wvalid_reg;
        winner_next    = winner_reg;
        winning_next   = winning_reg;
        run_next       = run_reg;
        scan_next      = scan_reg;
        out_next       = out_reg;
        mem_raddr      = slot_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                mem_raddr = IDX_W'(req.payload.slot);
                if (accept)
                begin
                    op_next     = req.payload.op;
                    slot_next   = IDX_W'(req.payload.slot);
                    blocks_next = req.payload.block_count;
                    rnd_next    = req.payload.random_value;
                    status_next = STATUS_OK;
                    wvalid_next = 1'b0;
                    winner_next = '0;
                    // a slot beyond the table is ignored
                    st_next     = in_range ? ST_UPD : ST_DONE;
                end
            end
            ST_UPD:
            begin
                pool_next   = upd_pool;
                status_next = upd_refused ? STATUS_REFUSED : STATUS_OK;
                if (op_reg == OP_QUANTUM)
                begin
                    if (upd_pool == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        st_next     = ST_DONE;
                    end
                    else
                    begin
                        st_next = ST_DIV;
                    end
                end
                else
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                mem_raddr = '0;
                if (div_done)
                begin
                    winning_next = div_rem;
                    run_next     = '0;
                    scan_next    = '0;
                    st_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one entry arrives per cycle, the next one is requested
                mem_raddr = scan_reg + 1'b1;
                run_next  = run_sum;
                scan_next = scan_reg + 1'b1;
                if (run_sum > RUN_W'(winning_reg))
                begin
                    wvalid_next = 1'b1;
                    winner_next = SLOT_W'(scan_reg);
                    st_next     = ST_DONE;
                end
                else if (scan_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.status       = status_reg;
                    out_next.winner_valid = wvalid_reg;
                    out_next.winner_slot  = winner_reg;
                    out_next.pool_total   = pool_reg;
                    out_valid_next        = 1'b1;
                    st_next               = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            pool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        blocks_reg  <= blocks_next;
        rnd_reg     <= rnd_next;
        status_reg  <= status_next;
        wvalid_reg  <= wvalid_next;
        winner_reg  <= winner_next;
        winning_reg <= winning_next;
        run_reg     <= run_next;
        scan_reg    <= scan_next;
        out_reg     <= out_next;
    end

    assign req.ready   = (st_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    `ASSERT_CLK(a_accept_next_state, clk, rst_n,
                accept |=> (st_reg == ST_UPD || st_reg == ST_DONE),
                "request not followed by update or response")
    `ASSERT_CLK(a_div_done_in_div, clk, rst_n, div_done |-> (st_reg == ST_DIV),
                "modulo finished outside its wait state")
    `ASSERT_NEVER(a_write_only_in_upd, clk, rst_n, mem_we && (st_reg != ST_UPD),
                  "ticket memory written outside the update step")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lts_pkg::*;

    localparam int SLOTS        = DEF_SLOT_COUNT;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE_TIME  = 120;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int REPORT_FIRST = 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lts_stream_if #(.payload_t(req_t)) req_if ();
    lts_stream_if #(.payload_t(rsp_t)) rsp_if ();

    lottery_ticket_scheduler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the scheduler state and its registers
    int                ticket_book [SLOTS];
    logic [POOL_W-1:0] pool_shadow;
    int                grant_sys;
    int                grant_usr;
    int                limit_shadow;
    int                threshold_shadow;

    rsp_t    pending_responses [$];
    int      mismatches = 0;
    longint  cycles = 0;
    bit      gaps_on;
    bit      stalls_on;
    int      stall_left = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, pending_responses.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void note_mismatch(input string field, input int exp_v,
                                          input int act_v);
        mismatches++;
        if (mismatches <= REPORT_FIRST)
            $display("mismatch on %s at %0t: expected %0d, actual %0d",
                     field, $realtime, exp_v, act_v);
    endfunction

    // adds tickets to a slot unless the limit forbids it, returns 1 when refused
    function automatic bit add_tickets(input int s, input int amount);
        int next_count;
        next_count = ticket_book[s] + amount;
        if (next_count > limit_shadow)
            return 1'b1;
        ticket_book[s] = next_count;
        pool_shadow    = pool_shadow + amount;
        return 1'b0;
    endfunction

    // expected response of one request, updating the shadow state
    function automatic rsp_t schedule_request(input req_t r);
        rsp_t o;
        int   s;
        bit   refused;
        int   draw;
        int   running;
        o = '0;
        s = r.slot;
        case (r.op)
            OP_START_SYS: o.status = add_tickets(s, grant_sys) ? STATUS_REFUSED : STATUS_OK;
            OP_START_USR: o.status = add_tickets(s, grant_usr) ? STATUS_REFUSED : STATUS_OK;
            OP_STOP:
            begin
                pool_shadow    = pool_shadow - ticket_book[s];
                ticket_book[s] = 0;
            end
            default:
            begin
                // adjust by one ticket, then draw
                if (int'(r.block_count) < threshold_shadow)
                begin
                    refused = ticket_book[s] < 2;
                    if (!refused)
                    begin
                        ticket_book[s]--;
                        pool_shadow = pool_shadow - 1;
                    end
                end
                else
                    refused = add_tickets(s, 1);
                o.status = refused ? STATUS_REFUSED : STATUS_OK;
                if (pool_shadow == 0)
                    o.status = STATUS_EMPTY;
                else
                begin
                    draw    = r.random_value % pool_shadow;
                    running = 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        running += ticket_book[i];
                        if (running > draw && !o.winner_valid)
                        begin
                            o.winner_valid = 1'b1;
                            o.winner_slot  = i[SLOT_W-1:0];
                        end
                    end
                end
            end
        endcase
        o.pool_total = pool_shadow;
        return o;
    endfunction

    // response checking
    always @(posedge clk)
    begin : check_rsp
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            if (pending_responses.size() == 0)
                note_mismatch("response with none pending, pool", -1, got.pool_total);
            else
            begin
                want = pending_responses.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", want.status, got.status);
                if (got.winner_valid !== want.winner_valid)
                    note_mismatch("winner_valid", want.winner_valid, got.winner_valid);
                if (got.winner_slot !== want.winner_slot)
                    note_mismatch("winner_slot", want.winner_slot, got.winner_slot);
                if (got.pool_total !== want.pool_total)
                    note_mismatch("pool_total", want.pool_total, got.pool_total);
            end
        end
    end

    // response back-pressure, mostly short stalls with the odd long one
    always @(posedge clk)
    begin : drive_ready
        int roll;
        roll = $urandom_range(0, 99);
        if (!stalls_on)
            rsp_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (roll < 4)
        begin
            stall_left = $urandom_range(10, 40);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= (roll >= 30);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request transaction; valid is left high for a following request
    task automatic send_request(input op_t op, input int slot, input int blocks,
                                input int draw);
        req_t r;
        int   gap;
        r.op           = op;
        r.slot         = slot[SLOT_W-1:0];
        r.block_count  = blocks[COUNT_W-1:0];
        r.random_value = draw[RANDOM_W-1:0];
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_responses.push_back(schedule_request(r));
    endtask

    // stop sending and wait for every outstanding response
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // write all four registers while the block is idle
    task automatic load_config(input int sys_g, input int usr_g, input int lim,
                               input int thr);
        logic [CFG_INDEX_W-1:0] regs [4];
        int                     vals [4];
        int                     i;
        regs = '{CFG_SYSTEM_GRANT, CFG_USER_GRANT, CFG_TICKET_LIMIT, CFG_BLOCK_THRESHOLD};
        vals = '{sys_g, usr_g, lim, thr};
        drain();
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        grant_sys        = sys_g & 'h7f;
        grant_usr        = usr_g & 'h7f;
        limit_shadow     = lim & 'h7f;
        threshold_shadow = thr & 'hffff;
    endtask

    // grants up to and past the limit at reset settings
    task automatic test_grant_limits();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_request(OP_START_SYS, 0, 0, 0);
        send_request(OP_START_USR, 0, 16'hffff, 16'hffff);
        send_request(OP_START_SYS, 0, 0, 0);
        send_request(OP_START_USR, 0, 0, 0);
        send_request(OP_START_SYS, 1, 0, 0);
        send_request(OP_STOP, 1, 0, 0);
    endtask

    // take and give around the floor, the limit and an empty pool
    task automatic test_quantum_cases();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_request(OP_QUANTUM, 0, 0, 0);
        send_request(OP_QUANTUM, 0, 16'hffff, 16'hffff);
        send_request(OP_QUANTUM, 0, 16'hffff, 16'h1234);
        send_request(OP_STOP, 0, 0, 0);
        send_request(OP_STOP, 0, 0, 0);
        send_request(OP_QUANTUM, 5, 0, 16'hffff);
        send_request(OP_QUANTUM, 63, 5, 16'hffff);
        send_request(OP_QUANTUM, 63, 4, 16'hffff);
        send_request(OP_START_USR, 63, 0, 0);
        send_request(OP_START_SYS, 1, 0, 0);
        send_request(OP_QUANTUM, 10, 100, 60);
    endtask

    // register extremes
    task automatic test_config_extremes();
        load_config(127, 127, 127, 0);
        send_request(OP_START_SYS, 2, 0, 0);
        send_request(OP_START_USR, 2, 0, 0);
        send_request(OP_QUANTUM, 2, 0, 16'haaaa);
        load_config(1, 1, 1, 16'hffff);
        send_request(OP_START_SYS, 2, 0, 0);
        send_request(OP_QUANTUM, 2, 0, 16'h5555);
        send_request(OP_QUANTUM, 2, 16'hffff, 16'hffff);
        send_request(OP_START_SYS, 3, 0, 0);
        send_request(OP_START_USR, 3, 0, 0);
        send_request(OP_STOP, 2, 0, 0);
    endtask

    // phases of random traffic, each under its own register settings
    task automatic test_random_traffic();
        int   phase;
        int   n;
        int   roll;
        int   stop_pct;
        int   slot;
        int   blocks;
        int   thr;
        op_t  op;
        for (phase = 0; phase < PHASES; phase++)
        begin
            roll = $urandom_range(0, 3);
            thr  = (roll == 0) ? 0 :
                   (roll == 1) ? 16'hffff :
                   (roll == 2) ? $urandom_range(0, 16) : $urandom_range(0, 16'hffff);
            case (phase)
                1: load_config(127, 127, 127, 16'hffff);
                2: load_config(1, 1, 1, 0);
                default: load_config($urandom_range(1, 127), $urandom_range(1, 127),
                                     $urandom_range(1, 127), thr);
            endcase
            gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            stop_pct  = (phase == 4) ? 40 : 8;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // operation
                roll = $urandom_range(0, 99);
                if (roll < stop_pct)
                    op = OP_STOP;
                else if (roll < stop_pct + 20)
                    op = OP_START_SYS;
                else if (roll < stop_pct + 40)
                    op = OP_START_USR;
                else
                    op = OP_QUANTUM;
                // a few busy slots or anywhere
                slot = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, SLOTS - 1);
                // block count near the threshold, anywhere, or at an end
                roll = $urandom_range(0, 3);
                if (roll < 2)
                begin
                    blocks = threshold_shadow + int'($urandom_range(0, 4)) - 2;
                    if (blocks < 0)
                        blocks = 0;
                    if (blocks > 16'hffff)
                        blocks = 16'hffff;
                end
                else if (roll == 2)
                    blocks = $urandom_range(0, 16'hffff);
                else
                    blocks = $urandom_range(0, 1) ? 16'hffff : 0;
                send_request(op, slot, blocks, $urandom_range(0, 16'hffff));
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_SYSTEM_GRANT;
        cfg_data       <= '0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        foreach (ticket_book[i])
            ticket_book[i] = 0;
        pool_shadow      = '0;
        grant_sys        = SYSTEM_GRANT_RST;
        grant_usr        = USER_GRANT_RST;
        limit_shadow     = TICKET_LIMIT_RST;
        threshold_shadow = BLOCK_THRESHOLD_RST;
        gaps_on          = 1'b0;
        stalls_on        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_grant_limits();
        test_quantum_cases();
        test_config_extremes();
        test_random_traffic();

        // let any stray response show up before the verdict
        drain();
        repeat (SETTLE_TIME) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lts_pkg.sv
rtl/lts_stream_if.sv
rtl/lts_ticket_mem.sv
rtl/lts_mod_unit.sv
rtl/lottery_ticket_scheduler_top.sv
verif/tb_top.sv
